// ===== design/spmc_pkg.sv =====
`default_nettype none

package spmc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SEC_W   = 32;
    localparam int PAGE_W  = 32;
    localparam int AGE_W   = 32;

    localparam logic [SEC_W-1:0]  EMPTY_SECTOR = {SEC_W{1'b1}};
    localparam logic [PAGE_W-1:0] PAGE_RESET   = {PAGE_W{1'b1}};
    localparam logic [AGE_W-1:0]  AGE_RESET    = {AGE_W{1'b1}};

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [PAGE_W-1:0] hit_page;
        logic              empty;
        logic [IDX_W-1:0]  empty_idx;
        logic              min_set;
        logic [AGE_W-1:0]  min_age;
        logic [IDX_W-1:0]  min_idx;
    } t_tok;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [SEC_W-1:0]  sector;
        logic [PAGE_W-1:0] page;
        logic [AGE_W-1:0]  age;
    } t_wr;

endpackage

`default_nettype wire

// ===== design/spmc_cell.sv =====
`default_nettype none

module spmc_cell
    import spmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_id,
    input  wire logic [SEC_W-1:0]  i_sector,
    input  wire t_wr               i_wr,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok
);

    logic [SEC_W-1:0]  r_sector;
    logic [PAGE_W-1:0] r_page;
    logic [AGE_W-1:0]  r_age;
    t_tok              r_tok;
    t_tok              n_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector <= EMPTY_SECTOR;
            r_page   <= PAGE_RESET;
            r_age    <= AGE_RESET;
        end else if (i_wr.en && (i_wr.idx == i_id)) begin
            r_sector <= i_wr.sector;
            r_page   <= i_wr.page;
            r_age    <= i_wr.age;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && (r_sector == i_sector)) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = i_id;
            n_tok.hit_page = r_page;
        end
        if (!i_tok.empty && (r_sector == EMPTY_SECTOR)) begin
            n_tok.empty     = 1'b1;
            n_tok.empty_idx = i_id;
        end
        if (!i_tok.min_set || (r_age < i_tok.min_age)) begin
            n_tok.min_set = 1'b1;
            n_tok.min_age = r_age;
            n_tok.min_idx = i_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== design/sector_page_map_cache_core.sv =====
`default_nettype none

// Fully associative sector-to-page cache with ENTRIES entries held in a chain of
// cells. From acceptance, the request is registered, then the search token walks
// the chain one cell register at a time collecting the match, the first empty
// entry and the oldest entry, the finished token is latched, and then the chosen
// entry is written and the result loaded. The input reopens the cycle after that,
// so a new item is taken only after the previous search is done; a new item is
// taken while the previous result still waits on the output, and a finished
// search waits for the output register to free up.
// Stores of the all-ones sector are dropped and return hit = 0, page = 0; lookups
// do not refresh age. Reset empties every entry.
module sector_page_map_cache_core
    import spmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_req_type,
    input  wire logic [SEC_W-1:0]  i_sector,
    input  wire logic [PAGE_W-1:0] i_page,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_hit,
    output logic [PAGE_W-1:0]      o_out_page
);

    t_state            r_state;
    t_state            n_state;
    logic              r_launch;
    logic              r_req_type;
    logic [SEC_W-1:0]  r_sector;
    logic [PAGE_W-1:0] r_page;
    t_tok              r_fin;
    logic [AGE_W-1:0]  r_age_cnt;
    logic              r_o_valid;
    logic              r_o_hit;
    logic [PAGE_W-1:0] r_o_page;

    logic              in_acc;
    logic              out_free;
    logic              load_out;
    logic              res_hit;
    logic [PAGE_W-1:0] res_page;
    logic              reserved;
    logic [IDX_W-1:0]  sel_idx;
    t_wr               wr;
    t_tok              tok [ENTRIES+1];
    logic [ENTRIES-1:0] tok_valid;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign reserved = (r_sector == EMPTY_SECTOR);

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = r_launch;
    end

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            spmc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_id     (IDX_W'(k)),
                .i_sector (r_sector),
                .i_wr     (wr),
                .i_tok    (tok[k]),
                .o_tok    (tok[k+1])
            );
            assign tok_valid[k] = tok[k+1].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        priority if (r_fin.hit) begin
            sel_idx = r_fin.hit_idx;
        end else if (r_fin.empty) begin
            sel_idx = r_fin.empty_idx;
        end else begin
            sel_idx = r_fin.min_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        load_out  = 1'b0;
        res_hit   = 1'b0;
        res_page  = '0;
        wr        = '0;
        wr.idx    = sel_idx;
        wr.sector = r_sector;
        wr.page   = r_page;
        wr.age    = r_age_cnt + AGE_W'(1);
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (tok[ENTRIES].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (reserved) begin
                        res_hit  = 1'b0;
                        res_page = '0;
                    end else if (r_req_type == REQ_STORE) begin
                        wr.en    = 1'b1;
                        res_hit  = 1'b1;
                        res_page = r_page;
                    end else begin
                        res_hit  = r_fin.hit;
                        res_page = r_fin.hit ? r_fin.hit_page : '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch  <= 1'b0;
            r_age_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_launch <= in_acc;
            if (wr.en) begin
                r_age_cnt <= wr.age;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_type <= i_req_type;
            r_sector   <= i_sector;
            r_page     <= i_page;
        end
        if ((r_state == S_SWEEP) && tok[ENTRIES].valid) begin
            r_fin <= tok[ENTRIES];
        end
        if (load_out) begin
            r_o_hit  <= res_hit;
            r_o_page <= res_page;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_hit      = r_o_hit;
    assign o_out_page = r_o_page;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one search token in the chain");

    a_token_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok[ENTRIES].valid || r_launch) |-> (r_state == S_SWEEP))
        else $error("search token outside of a sweep");

    a_age_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |=> (r_age_cnt == $past(r_age_cnt) + AGE_W'(1)))
        else $error("age counter did not advance on a store");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> ((r_state == S_DONE) && out_free))
        else $error("result loaded outside of the done state");

endmodule

`default_nettype wire

// ===== verif/tb_sector_page_map_cache_core.sv =====
`timescale 1ns / 1ps

module tb_sector_page_map_cache_core;
    import spmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;
    localparam int TAIL_CYCLES = ENTRIES + 8;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] page;
    } t_map_result;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              i_req_type = REQ_LOOKUP;
    logic [SEC_W-1:0]  i_sector   = '0;
    logic [PAGE_W-1:0] i_page     = '0;
    logic              i_ready    = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_hit;
    logic [PAGE_W-1:0] o_out_page;

    logic [SEC_W-1:0]  cache_sector [ENTRIES];
    logic [PAGE_W-1:0] cache_page   [ENTRIES];
    logic [AGE_W-1:0]  cache_age    [ENTRIES];
    logic [AGE_W-1:0]  store_count;

    t_map_result       expected_maps [$];
    t_map_result       want;
    logic [SEC_W-1:0]  sector_pool [POOL_SIZE];

    int  mismatches = 0;
    int  cycle_cnt  = 0;
    int  stall_left = 0;
    bit  gaps_on    = 1'b1;

    sector_page_map_cache_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_sector   (i_sector),
        .i_page     (i_page),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_out_page (o_out_page)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!gaps_on) begin
            stall_left <= 0;
            i_ready    <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 12);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0b page=%h", o_hit, o_out_page);
            end else begin
                want = expected_maps.pop_front();
                if (o_hit !== want.hit || o_out_page !== want.page) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected hit=%0b page=%h, got hit=%0b page=%h",
                                 want.hit, want.page, o_hit, o_out_page);
                end
            end
        end
    end

    function automatic void clear_cache_model();
        for (int i = 0; i < ENTRIES; i++) begin
            cache_sector[i] = EMPTY_SECTOR;
            cache_page[i]   = PAGE_RESET;
            cache_age[i]    = AGE_RESET;
        end
        store_count = '0;
    endfunction

    function automatic void map_cache_apply(input logic req, input logic [SEC_W-1:0] sec,
                                            input logic [PAGE_W-1:0] pg,
                                            output t_map_result res);
        int slot;
        int oldest;
        res = '0;
        slot = -1;
        if (sec == EMPTY_SECTOR)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && cache_sector[i] == sec)
                slot = i;
        end
        if (req == REQ_LOOKUP) begin
            if (slot >= 0) begin
                res.hit  = 1'b1;
                res.page = cache_page[slot];
            end
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && cache_sector[i] == EMPTY_SECTOR)
                slot = i;
        end
        if (slot < 0) begin
            oldest = 0;
            for (int i = 1; i < ENTRIES; i++) begin
                if (cache_age[i] < cache_age[oldest])
                    oldest = i;
            end
            slot = oldest;
        end
        store_count        = store_count + 1'b1;
        cache_sector[slot] = sec;
        cache_page[slot]   = pg;
        cache_age[slot]    = store_count;
        res.hit  = 1'b1;
        res.page = pg;
    endfunction

    task automatic send_item(input logic req, input logic [SEC_W-1:0] sec,
                             input logic [PAGE_W-1:0] pg);
        t_map_result res;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_sector   <= sec;
        i_page     <= pg;
        do @(posedge i_clk); while (!o_ready);
        map_cache_apply(req, sec, pg, res);
        expected_maps.push_back(res);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_maps.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [SEC_W-1:0] pick_sector();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return EMPTY_SECTOR;
        if (r < 6)  return '0;
        if (r < 9)  return EMPTY_SECTOR - 1'b1;
        if (r < 20) return $urandom();
        return sector_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return PAGE_RESET;
        return $urandom();
    endfunction

    task automatic send_random(input int count);
        logic req;
        for (int n = 0; n < count; n++) begin
            req = ($urandom_range(0, 9) < 4) ? REQ_STORE : REQ_LOOKUP;
            send_item(req, pick_sector(), pick_page());
        end
    endtask

    task automatic test_empty_after_reset();
        send_item(REQ_LOOKUP, '0, '0);
        send_item(REQ_LOOKUP, EMPTY_SECTOR - 1'b1, PAGE_RESET);
        send_item(REQ_LOOKUP, EMPTY_SECTOR, '0);
    endtask

    task automatic test_store_and_reserved();
        send_item(REQ_STORE, '0, '0);
        send_item(REQ_STORE, EMPTY_SECTOR - 1'b1, PAGE_RESET);
        send_item(REQ_LOOKUP, '0, PAGE_RESET);
        send_item(REQ_LOOKUP, EMPTY_SECTOR - 1'b1, '0);
        send_item(REQ_STORE, EMPTY_SECTOR, 32'h1234_5678);
        send_item(REQ_LOOKUP, EMPTY_SECTOR, '0);
        send_item(REQ_STORE, '0, 32'h5A5A_A5A5);
    endtask

    task automatic test_fill_and_evict();
        for (int k = 0; k < ENTRIES - 2; k++)
            send_item(REQ_STORE, 32'h8000_0001 << (k % 2) ^ k, 32'hC000_0000 | k);
        send_item(REQ_STORE, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_item(REQ_LOOKUP, EMPTY_SECTOR - 1'b1, '0);
        send_item(REQ_LOOKUP, '0, '0);
    endtask

    task automatic test_random_traffic();
        send_random(600);
        drain_results();
        send_random(650);
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        send_random(380);
    endtask

    initial begin
        logic [SEC_W-1:0] base;
        clear_cache_model();
        base = $urandom();
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 2 == 0)
                sector_pool[i] = $urandom();
            else
                sector_pool[i] = base ^ (32'h1 << $urandom_range(0, SEC_W - 1));
            if (sector_pool[i] == EMPTY_SECTOR)
                sector_pool[i] = base;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_after_reset();
        test_store_and_reserved();
        test_fill_and_evict();
        test_random_traffic();
        test_full_rate();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatches += expected_maps.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/spmc_pkg.sv
design/spmc_cell.sv
design/sector_page_map_cache_core.sv
verif/tb_sector_page_map_cache_core.sv
